>>> rtl/lns_pkg.sv
// lns_pkg: shared types, codes and constants for the lcd nibble sequencer
// no dependencies; every other file but lns_if uses it by scoped names
`timescale 1ns / 1ps

package lns_pkg;

	localparam int MAX_RESULTS = 6;
	localparam int RES_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] CMD_WRITE_CMD  = 3'd0;
	localparam logic [2:0] CMD_WRITE_DATA = 3'd1;
	localparam logic [2:0] CMD_INIT       = 3'd2;
	localparam logic [2:0] CMD_DRAW       = 3'd3;
	localparam logic [2:0] CMD_REPLY      = 3'd4;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic [7:0] PIN_RS  = 8'h01;
	localparam logic [7:0] PIN_RW  = 8'h02;
	localparam logic [7:0] PIN_E   = 8'h04;
	localparam logic [7:0] PIN_DAT = 8'hF0;
	localparam logic [7:0] PIN_BUS_4BIT = 8'h20;
	localparam logic [7:0] DDRAM_BASE   = 8'h80;
	localparam logic [7:0] ROW_ODD_OFS  = 8'h40;
	localparam logic [7:0] ROW_HIGH_OFS = 8'h14;
	localparam logic [2:0] INIT_LAST_STEP = 3'd6;

	localparam logic [0:0] REG_EXP_ADDR   = 1'b0;
	localparam logic [2:0] ADDR_EXP_ADDR  = 3'd0;
	localparam logic [6:0] EXP_ADDR_RESET = 7'd39;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_BUSY_FIRST,
		PH_POLL,
		PH_FETCH
	} phase_t;

	// one request's worth of expander transactions
	typedef struct packed {
		logic [RES_IDX_W-1:0]               count;
		logic [MAX_RESULTS-1:0][1:0]        kind;
		logic [MAX_RESULTS-1:0][7:0]        data;
	} job_t;

	// lcd commands sent after the switch to 4-bit mode
	function automatic logic [7:0] init_cmd(input logic [2:0] step);
		logic [7:0] v;
		unique case (step)
			3'd1: v = 8'h28;
			3'd2: v = 8'h08;
			3'd3: v = 8'h06;
			3'd4: v = 8'h01;
			3'd5: v = 8'h0C;
			3'd6: v = 8'h80;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/lns_if.sv
// lns_req_if and lns_res_if: valid/ready channels for requests and expander transactions
// depends on nothing but the port widths of the block
`timescale 1ns / 1ps

interface lns_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] byte_value;
	logic [5:0] column;
	logic [1:0] row;
	logic [7:0] reply_byte;

	modport source (output valid, cmd, byte_value, column, row, reply_byte, input ready);
	modport sink (input valid, cmd, byte_value, column, row, reply_byte, output ready);
endinterface

interface lns_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] bus_address_byte;
	logic [7:0] bus_byte;
	logic       last;

	modport source (output valid, kind, bus_address_byte, bus_byte, last, input ready);
	modport sink (input valid, kind, bus_address_byte, bus_byte, last, output ready);
endinterface

>>> rtl/lcd_nibble_sequencer_over_expander.sv
// lcd_nibble_sequencer_over_expander: top level, apb register, front, queue and back end
// uses lns_pkg, lns_if, lns_front, lns_queue, lns_back
//
// channel  dir  handshake        payload
// req      in   valid/ready      cmd, byte_value, column, row, reply_byte
// res      out  valid/ready      kind, bus_address_byte, bus_byte, last
// apb      in   psel/penable     paddr, pwdata, prdata (expander_address at 0)
//
// a request yields one to six expander transactions, one per cycle from the back end
// while res does not stall, so requests go no faster than their transactions drain
// the front takes a request in the cycle it arrives while the job queue has room
// res stalls hold the output register and fill the queue before req.ready falls
// reset clears the sequence state, the queue and the output; expander_address is 39
`timescale 1ns / 1ps

module lcd_nibble_sequencer_over_expander #(
	parameter int QueueDepth = lns_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	lns_req_if.sink     req,
	lns_res_if.source   res
);

	logic [6:0]    expander_address_q;
	logic          push;
	logic          full;
	logic          pop;
	logic          not_empty;
	lns_pkg::job_t push_job;
	lns_pkg::job_t head;

	assign pready = 1'b1;
	assign prdata = (paddr == lns_pkg::ADDR_EXP_ADDR) ? {25'd0, expander_address_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expander_address_q <= lns_pkg::EXP_ADDR_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr == lns_pkg::ADDR_EXP_ADDR) begin
			expander_address_q <= pwdata[6:0];
		end
	end

	lns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.queue_full (full),
		.push       (push),
		.job        (push_job)
	);

	lns_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	lns_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.expander_address (expander_address_q),
		.job_valid        (not_empty),
		.job_head         (head),
		.pop              (pop),
		.res              (res)
	);

endmodule

>>> rtl/lns_front.sv
// lns_front: accepts requests and replies, tracks the lcd sequence state and
// turns each transaction into a job of expander transactions; uses lns_pkg
`timescale 1ns / 1ps

module lns_front (
	input  logic            clk,
	input  logic            arst_n,
	lns_req_if.sink         req,
	input  logic            queue_full,
	output logic            push,
	output lns_pkg::job_t   job
);

	lns_pkg::phase_t phase_q, phase_nx;
	logic [7:0] pin_shadow_q, pin_shadow_nx;
	logic [7:0] pending_byte_q, pending_byte_nx;
	logic       pending_select_q, pending_select_nx;
	logic [7:0] queued_char_q, queued_char_nx;
	logic       char_queued_q, char_queued_nx;
	logic [2:0] init_step_q, init_step_nx;
	logic       init_active_q, init_active_nx;

	assign req.ready = !queue_full;
	assign push = req.valid && !queue_full;

	always_comb begin
		logic       idle;
		logic       bad;
		logic       adv_start;
		logic [7:0] r;
		logic [7:0] t;
		logic [7:0] t2;
		logic [7:0] draw_addr;
		idle = (phase_q == lns_pkg::PH_IDLE);
		r = req.reply_byte;
		bad = (req.cmd > lns_pkg::CMD_REPLY)
			|| (req.cmd < lns_pkg::CMD_REPLY && !idle)
			|| (req.cmd == lns_pkg::CMD_REPLY && idle);
		adv_start = 1'b0;
		t = '0;
		t2 = '0;
		draw_addr = lns_pkg::DDRAM_BASE
			+ (req.row[0] ? lns_pkg::ROW_ODD_OFS : 8'h00)
			+ (req.row[1] ? lns_pkg::ROW_HIGH_OFS : 8'h00)
			+ {2'b00, req.column};

		phase_nx = phase_q;
		pin_shadow_nx = pin_shadow_q;
		pending_byte_nx = pending_byte_q;
		pending_select_nx = pending_select_q;
		queued_char_nx = queued_char_q;
		char_queued_nx = char_queued_q;
		init_step_nx = init_step_q;
		init_active_nx = init_active_q;
		job = '0;

		if (bad) begin
			job.count = 3'd1;
			job.kind[0] = lns_pkg::KIND_REJECT;
		end else if (req.cmd == lns_pkg::CMD_REPLY) begin
			unique case (phase_q)
				lns_pkg::PH_BUSY_FIRST: begin
					t = (r & ~(lns_pkg::PIN_E | lns_pkg::PIN_RS)) | lns_pkg::PIN_RW
						| lns_pkg::PIN_DAT;
					job.count = 3'd3;
					job.kind[0] = lns_pkg::KIND_WRITE;
					job.data[0] = t;
					job.kind[1] = lns_pkg::KIND_WRITE;
					job.data[1] = t | lns_pkg::PIN_E;
					job.kind[2] = lns_pkg::KIND_READ;
					pin_shadow_nx = t | lns_pkg::PIN_E;
					phase_nx = lns_pkg::PH_POLL;
				end
				lns_pkg::PH_POLL: begin
					t = pin_shadow_q;
					job.kind[0] = lns_pkg::KIND_WRITE;
					job.data[0] = t & ~lns_pkg::PIN_E;
					if (r[7]) begin
						job.count = 3'd3;
						job.kind[1] = lns_pkg::KIND_WRITE;
						job.data[1] = t | lns_pkg::PIN_E;
						job.kind[2] = lns_pkg::KIND_READ;
						pin_shadow_nx = t | lns_pkg::PIN_E;
					end else begin
						job.count = 3'd2;
						job.kind[1] = lns_pkg::KIND_READ;
						pin_shadow_nx = t & ~lns_pkg::PIN_E;
						phase_nx = lns_pkg::PH_FETCH;
					end
				end
				lns_pkg::PH_FETCH: begin
					// advance to the next transfer, if any
					if (init_active_q) begin
						if (init_step_q < lns_pkg::INIT_LAST_STEP) begin
							init_step_nx = init_step_q + 3'd1;
							pending_byte_nx = lns_pkg::init_cmd(init_step_q + 3'd1);
							pending_select_nx = 1'b0;
							adv_start = 1'b1;
						end else begin
							init_active_nx = 1'b0;
							init_step_nx = '0;
						end
					end else if (char_queued_q) begin
						char_queued_nx = 1'b0;
						pending_byte_nx = queued_char_q;
						pending_select_nx = 1'b1;
						adv_start = 1'b1;
					end
					phase_nx = adv_start ? lns_pkg::PH_BUSY_FIRST : lns_pkg::PH_IDLE;

					if (init_active_q && init_step_q == 3'd0) begin
						t = (r & ~(lns_pkg::PIN_RS | lns_pkg::PIN_RW | lns_pkg::PIN_E
							| lns_pkg::PIN_DAT)) | lns_pkg::PIN_BUS_4BIT;
						job.count = adv_start ? 3'd4 : 3'd3;
						job.kind[0] = lns_pkg::KIND_WRITE;
						job.data[0] = t;
						job.kind[1] = lns_pkg::KIND_WRITE;
						job.data[1] = t | lns_pkg::PIN_E;
						job.kind[2] = lns_pkg::KIND_WRITE;
						job.data[2] = t;
						job.kind[3] = lns_pkg::KIND_READ;
						pin_shadow_nx = t;
					end else begin
						t = (r & ~(lns_pkg::PIN_RS | lns_pkg::PIN_RW | lns_pkg::PIN_E
							| lns_pkg::PIN_DAT))
							| (pending_select_q ? lns_pkg::PIN_RS : 8'h00)
							| (pending_byte_q & lns_pkg::PIN_DAT);
						t2 = (t & ~(lns_pkg::PIN_E | lns_pkg::PIN_DAT))
							| {pending_byte_q[3:0], 4'h0};
						job.count = adv_start ? 3'd6 : 3'd5;
						job.kind[0] = lns_pkg::KIND_WRITE;
						job.data[0] = t;
						job.kind[1] = lns_pkg::KIND_WRITE;
						job.data[1] = t | lns_pkg::PIN_E;
						job.kind[2] = lns_pkg::KIND_WRITE;
						job.data[2] = t2;
						job.kind[3] = lns_pkg::KIND_WRITE;
						job.data[3] = t2 | lns_pkg::PIN_E;
						job.kind[4] = lns_pkg::KIND_WRITE;
						job.data[4] = t2;
						job.kind[5] = lns_pkg::KIND_READ;
						pin_shadow_nx = t2;
					end
				end
				default: begin
					job.count = 3'd1;
					job.kind[0] = lns_pkg::KIND_REJECT;
				end
			endcase
		end else begin
			// new transfer: first a busy-flag read
			job.count = 3'd1;
			job.kind[0] = lns_pkg::KIND_READ;
			phase_nx = lns_pkg::PH_BUSY_FIRST;
			unique case (req.cmd)
				lns_pkg::CMD_INIT: begin
					init_active_nx = 1'b1;
					init_step_nx = '0;
					pending_byte_nx = 8'h00;
					pending_select_nx = 1'b0;
				end
				lns_pkg::CMD_DRAW: begin
					queued_char_nx = req.byte_value;
					char_queued_nx = 1'b1;
					pending_byte_nx = draw_addr;
					pending_select_nx = 1'b0;
				end
				default: begin
					pending_byte_nx = req.byte_value;
					pending_select_nx = req.cmd[0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lns_pkg::PH_IDLE;
			pin_shadow_q <= '0;
			pending_byte_q <= '0;
			pending_select_q <= 1'b0;
			queued_char_q <= '0;
			char_queued_q <= 1'b0;
			init_step_q <= '0;
			init_active_q <= 1'b0;
		end else if (push) begin
			phase_q <= phase_nx;
			pin_shadow_q <= pin_shadow_nx;
			pending_byte_q <= pending_byte_nx;
			pending_select_q <= pending_select_nx;
			queued_char_q <= queued_char_nx;
			char_queued_q <= char_queued_nx;
			init_step_q <= init_step_nx;
			init_active_q <= init_active_nx;
		end
	end

endmodule

>>> rtl/lns_queue.sv
// lns_queue: short job queue between the front and the back end
// uses lns_pkg for the job type
`timescale 1ns / 1ps

module lns_queue #(
	parameter int DEPTH = lns_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lns_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output lns_pkg::job_t head
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	lns_pkg::job_t         mem_q [DEPTH];
	logic [PtrW-1:0]       wr_ptr_q;
	logic [PtrW-1:0]       rd_ptr_q;
	logic [CntW-1:0]       count_q;

	assign full = (count_q == CntW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop) rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CntW'(1);
			else if (pop && !push) count_q <= count_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

endmodule

>>> rtl/lns_back.sv
// lns_back: plays out queued jobs one expander transaction per cycle while res does not stall,
// into an output register; uses lns_pkg and lns_res_if
`timescale 1ns / 1ps

module lns_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [6:0]    expander_address,
	input  logic          job_valid,
	input  lns_pkg::job_t job_head,
	output logic          pop,
	lns_res_if.source     res
);

	lns_pkg::job_t                   cur_q;
	logic                            cur_valid_q;
	logic [lns_pkg::RES_IDX_W-1:0]   idx_q;
	logic                            out_valid_q;
	logic [1:0]                      kind_q;
	logic [7:0]                      addr_q;
	logic [7:0]                      data_q;
	logic                            last_q;

	logic                            out_free;
	logic                            step;
	logic                            cur_last;
	logic [1:0]                      cur_kind;

	assign out_free = !out_valid_q || res.ready;
	assign step = cur_valid_q && out_free;
	assign cur_last = (idx_q == cur_q.count - lns_pkg::RES_IDX_W'(1));
	assign pop = job_valid && (!cur_valid_q || (step && cur_last));
	assign cur_kind = cur_q.kind[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q <= '0;
			end else if (step && cur_last) begin
				cur_valid_q <= 1'b0;
			end else if (step) begin
				idx_q <= idx_q + lns_pkg::RES_IDX_W'(1);
			end
			if (step) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= job_head;
		if (step) begin
			kind_q <= cur_kind;
			data_q <= cur_q.data[idx_q];
			last_q <= cur_last;
			priority if (cur_kind == lns_pkg::KIND_READ) addr_q <= {expander_address, 1'b1};
			else if (cur_kind == lns_pkg::KIND_WRITE) addr_q <= {expander_address, 1'b0};
			else addr_q <= 8'h00;
		end
	end

	assign res.valid = out_valid_q;
	assign res.kind = kind_q;
	assign res.bus_address_byte = addr_q;
	assign res.bus_byte = data_q;
	assign res.last = last_q;

endmodule

>>> test/expander_txn_check.sv
// expander_txn_check: watches the request, transaction and apb ports of the lcd sequencer
// predicts every expander transaction and compares each one; depends on lns_pkg and lns_if
`timescale 1ns / 1ps

module expander_txn_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	lns_req_if          req,
	lns_res_if          res,
	output int          mismatches,
	output int          txns_in_flight
);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] address_byte;
		logic [7:0] pin_byte;
		logic       last;
	} bus_txn_t;

	logic [7:0]      setup_bytes [0:6];
	logic [6:0]      exp_addr;
	lns_pkg::phase_t phase;
	logic [7:0]      pin_shadow;
	logic [7:0]      pend_byte;
	logic            pend_rs;
	logic [7:0]      char_byte;
	logic            char_waiting;
	logic [2:0]      setup_step;
	logic            setup_running;
	bus_txn_t        expected_txns [$];
	bus_txn_t        new_txns [$];
	int              miss_total;

	initial begin
		setup_bytes = '{8'h00, 8'h28, 8'h08, 8'h06, 8'h01, 8'h0C, 8'h80};
	end

	task automatic report(input string what, input int got, input int want);
		$display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
		miss_total++;
	endtask

	task automatic push_txn(input logic [1:0] k, input logic [7:0] a, input logic [7:0] d);
		bus_txn_t t;
		t.kind = k;
		t.address_byte = a;
		t.pin_byte = d;
		t.last = 1'b0;
		new_txns.push_back(t);
	endtask

	task automatic pin_write(input logic [7:0] v);
		pin_shadow = v;
		push_txn(lns_pkg::KIND_WRITE, {exp_addr, 1'b0}, v);
	endtask

	task automatic pin_read();
		push_txn(lns_pkg::KIND_READ, {exp_addr, 1'b1}, 8'h00);
	endtask

	task automatic begin_transfer(input logic [7:0] v, input logic rs);
		pend_byte = v;
		pend_rs = rs;
		phase = lns_pkg::PH_BUSY_FIRST;
		pin_read();
	endtask

	task automatic next_transfer();
		if (setup_running && setup_step < lns_pkg::INIT_LAST_STEP) begin
			setup_step = setup_step + 3'd1;
			begin_transfer(setup_bytes[setup_step], 1'b0);
		end else if (!setup_running && char_waiting) begin
			char_waiting = 1'b0;
			begin_transfer(char_byte, 1'b1);
		end else begin
			setup_running = 1'b0;
			setup_step = 3'd0;
			phase = lns_pkg::PH_IDLE;
		end
	endtask

	task automatic take_reply(input logic [7:0] r);
		logic [7:0] t;
		case (phase)
			lns_pkg::PH_BUSY_FIRST: begin
				t = (r & ~(lns_pkg::PIN_E | lns_pkg::PIN_RS)) | lns_pkg::PIN_RW | lns_pkg::PIN_DAT;
				pin_write(t);
				pin_write(t | lns_pkg::PIN_E);
				pin_read();
				phase = lns_pkg::PH_POLL;
			end
			lns_pkg::PH_POLL: begin
				t = pin_shadow;
				pin_write(t & ~lns_pkg::PIN_E);
				if (r[7]) begin
					pin_write(t | lns_pkg::PIN_E);
					pin_read();
				end else begin
					pin_read();
					phase = lns_pkg::PH_FETCH;
				end
			end
			default: begin
				t = r & ~(lns_pkg::PIN_RS | lns_pkg::PIN_RW | lns_pkg::PIN_E | lns_pkg::PIN_DAT);
				if (setup_running && setup_step == 3'd0) begin
					// switch to 4-bit bus: one nibble only
					t = t | lns_pkg::PIN_BUS_4BIT;
					pin_write(t);
					pin_write(t | lns_pkg::PIN_E);
					pin_write(t);
				end else begin
					if (pend_rs)
						t = t | lns_pkg::PIN_RS;
					t = t | (pend_byte & lns_pkg::PIN_DAT);
					pin_write(t);
					pin_write(t | lns_pkg::PIN_E);
					t = (t & ~(lns_pkg::PIN_E | lns_pkg::PIN_DAT)) | {pend_byte[3:0], 4'h0};
					pin_write(t);
					pin_write(t | lns_pkg::PIN_E);
					pin_write(t);
				end
				next_transfer();
			end
		endcase
	endtask

	task automatic predict_request(input logic [2:0] c, input logic [7:0] v,
			input logic [5:0] col, input logic [1:0] rw, input logic [7:0] rep);
		logic [7:0] ddram;
		if (c > lns_pkg::CMD_REPLY || (c < lns_pkg::CMD_REPLY && phase != lns_pkg::PH_IDLE)
				|| (c == lns_pkg::CMD_REPLY && phase == lns_pkg::PH_IDLE)) begin
			push_txn(lns_pkg::KIND_REJECT, 8'h00, 8'h00);
		end else begin
			case (c)
				lns_pkg::CMD_REPLY: take_reply(rep);
				lns_pkg::CMD_INIT: begin
					setup_running = 1'b1;
					setup_step = 3'd0;
					begin_transfer(8'h00, 1'b0);
				end
				lns_pkg::CMD_DRAW: begin
					ddram = lns_pkg::DDRAM_BASE + (rw[0] ? lns_pkg::ROW_ODD_OFS : 8'h00)
						+ (rw[1] ? lns_pkg::ROW_HIGH_OFS : 8'h00) + {2'b00, col};
					char_byte = v;
					char_waiting = 1'b1;
					begin_transfer(ddram, 1'b0);
				end
				default: begin_transfer(v, c[0]);
			endcase
		end
		if (new_txns.size() > 0)
			new_txns[new_txns.size() - 1].last = 1'b1;
		while (new_txns.size() > 0)
			expected_txns.push_back(new_txns.pop_front());
	endtask

	always @(posedge clk or negedge arst_n) begin
		bus_txn_t want;
		if (!arst_n) begin
			exp_addr = lns_pkg::EXP_ADDR_RESET;
			phase = lns_pkg::PH_IDLE;
			pin_shadow = 8'h00;
			pend_byte = 8'h00;
			pend_rs = 1'b0;
			char_byte = 8'h00;
			char_waiting = 1'b0;
			setup_step = 3'd0;
			setup_running = 1'b0;
			expected_txns.delete();
			new_txns.delete();
			miss_total = 0;
			mismatches <= 0;
			txns_in_flight <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == lns_pkg::ADDR_EXP_ADDR)
				exp_addr = pwdata[6:0];
			if (res.valid && res.ready) begin
				if (expected_txns.size() == 0) begin
					report("transaction with nothing expected, kind", res.kind, 0);
				end else begin
					want = expected_txns.pop_front();
					if (res.kind !== want.kind)
						report("kind", res.kind, want.kind);
					if (res.bus_address_byte !== want.address_byte)
						report("bus_address_byte", res.bus_address_byte, want.address_byte);
					if (res.bus_byte !== want.pin_byte)
						report("bus_byte", res.bus_byte, want.pin_byte);
					if (res.last !== want.last)
						report("last", res.last, want.last);
				end
			end
			if (req.valid && req.ready)
				predict_request(req.cmd, req.byte_value, req.column, req.row, req.reply_byte);
			mismatches <= miss_total;
			txns_in_flight <= expected_txns.size();
		end
	end

endmodule

>>> test/lcd_nibble_sequencer_over_expander_tb.sv
// lcd_nibble_sequencer_over_expander_tb: drives lcd requests, expander replies and apb writes
// with random gaps and stalls; uses lns_pkg, lns_if and expander_txn_check
`timescale 1ns / 1ps

module lcd_nibble_sequencer_over_expander_tb;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 84;
	localparam int HOLD_AFTER_ITEMS = 130;
	localparam logic [7:0] BUSY_FLAG = 8'h80;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          lcd_mismatches;
	int          txns_in_flight;
	int          cycle_count = 0;
	int          items_sent = 0;
	int          calm_left = 0;

	lns_req_if req ();
	lns_res_if res ();

	lcd_nibble_sequencer_over_expander uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req),
		.res(res)
	);

	expander_txn_check txn_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.req(req),
		.res(res),
		.mismatches(lcd_mismatches),
		.txns_in_flight(txns_in_flight)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL lcd_nibble_sequencer_over_expander");
			$finish;
		end
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic [2:0] c, input logic [7:0] v, input logic [5:0] col,
			input logic [1:0] rw, input logic [7:0] rep);
		int gap;
		req.valid <= 1'b1;
		req.cmd <= c;
		req.byte_value <= v;
		req.column <= col;
		req.row <= rw;
		req.reply_byte <= rep;
		do @(posedge clk); while (!req.ready);
		items_sent++;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			gap = idle_span();
			if ($urandom_range(0, 49) == 0)
				calm_left = $urandom_range(15, 40);
		end
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_reply(input logic [7:0] r);
		send_item(lns_pkg::CMD_REPLY, 8'($urandom), 6'($urandom), 2'($urandom), r);
	endtask

	// a rejected transaction: mid-sequence request, stray reply or unknown command
	task automatic send_noise(input logic at_idle);
		logic [2:0] c;
		if (at_idle) begin
			c = 3'($urandom_range(4, 7));
		end else begin
			c = 3'($urandom_range(0, 6));
			if (c >= lns_pkg::CMD_REPLY)
				c = c + 3'd1;
		end
		send_item(c, 8'($urandom), 6'($urandom), 2'($urandom), 8'($urandom));
	endtask

	task automatic maybe_noise();
		if ($urandom_range(0, 99) < 6)
			send_noise(1'b0);
	endtask

	task automatic answer_transfer();
		int busy_polls;
		busy_polls = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		maybe_noise();
		send_reply(8'($urandom));
		repeat (busy_polls) begin
			maybe_noise();
			send_reply(8'($urandom) | BUSY_FLAG);
		end
		maybe_noise();
		send_reply(8'($urandom) & ~BUSY_FLAG);
		maybe_noise();
		send_reply(8'($urandom));
	endtask

	task automatic run_sequence();
		int pick;
		int transfers;
		logic [2:0] c;
		logic [5:0] col;
		if ($urandom_range(0, 99) < 8)
			send_noise(1'b1);
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			c = lns_pkg::CMD_WRITE_CMD;
			transfers = 1;
		end else if (pick < 60) begin
			c = lns_pkg::CMD_WRITE_DATA;
			transfers = 1;
		end else if (pick < 85) begin
			c = lns_pkg::CMD_DRAW;
			transfers = 2;
		end else begin
			c = lns_pkg::CMD_INIT;
			transfers = 7;
		end
		col = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63)) : 6'($urandom_range(0, 39));
		send_item(c, 8'($urandom), col, 2'($urandom), 8'($urandom));
		repeat (transfers) answer_transfer();
	endtask

	task automatic run_directed();
		send_reply(8'hFF);
		for (int k = 1; k <= 3; k++)
			send_item(lns_pkg::CMD_REPLY + 3'(k), 8'hFF, 6'd63, 2'd3, 8'hFF);
		// command byte with one busy poll
		send_item(lns_pkg::CMD_WRITE_CMD, 8'hFF, 6'd0, 2'd0, 8'h00);
		send_reply(8'hFF);
		send_reply(8'hFF);
		send_reply(8'h7F);
		send_reply(8'hFF);
		// data byte, with requests refused mid-sequence
		send_item(lns_pkg::CMD_WRITE_DATA, 8'h00, 6'd0, 2'd0, 8'h00);
		send_item(lns_pkg::CMD_INIT, 8'h00, 6'd0, 2'd0, 8'h00);
		send_item(lns_pkg::CMD_DRAW, 8'hFF, 6'd63, 2'd3, 8'hFF);
		send_reply(8'h00);
		send_reply(8'h00);
		send_reply(8'h00);
		// draw at the last row and column, address wraps
		send_item(lns_pkg::CMD_DRAW, 8'hA5, 6'd63, 2'd3, 8'h00);
		for (int k = 0; k < 2; k++) begin
			send_reply(k == 0 ? 8'h08 : 8'hF7);
			send_reply(8'h00);
			send_reply(k == 0 ? 8'h08 : 8'hF7);
			send_reply(k == 0 ? 8'h08 : 8'hF7);
		end
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (txns_in_flight != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_exp_addr(input logic [6:0] a);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= lns_pkg::ADDR_EXP_ADDR;
		pwdata <= {25'd0, a};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin : res_ready_driver
		int span;
		logic held_long;
		held_long = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			span = ($urandom_range(0, 99) < 10) ? $urandom_range(40, 120) : $urandom_range(1, 12);
			res.ready <= 1'b1;
			repeat (span) @(posedge clk);
			// one long hold-off mid-run so the queue fills and req.ready drops
			if (!held_long && items_sent > HOLD_AFTER_ITEMS) begin
				held_long = 1'b1;
				span = 400;
			end else begin
				span = idle_span();
			end
			if (span > 0) begin
				res.ready <= 1'b0;
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int start;
		logic [6:0] a;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.cmd = '0;
		req.byte_value = '0;
		req.column = '0;
		req.row = '0;
		req.reply_byte = '0;
		res.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		settle();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: a = 7'h00;
				1: a = 7'h7F;
				4: a = lns_pkg::EXP_ADDR_RESET;
				default: a = 7'($urandom_range(1, 126));
			endcase
			write_exp_addr(a);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS)
				run_sequence();
			settle();
		end
		if (lcd_mismatches == 0)
			$display("PASS lcd_nibble_sequencer_over_expander");
		else
			$display("FAIL lcd_nibble_sequencer_over_expander");
		$finish;
	end

endmodule

>>> sim.f
rtl/lns_pkg.sv
rtl/lns_if.sv
rtl/lns_front.sv
rtl/lns_queue.sv
rtl/lns_back.sv
rtl/lcd_nibble_sequencer_over_expander.sv
test/expander_txn_check.sv
test/lcd_nibble_sequencer_over_expander_tb.sv
